// ===== rtl/core/peer_learning_forward_table_defines.svh =====
// ---------------------------------------------------------------------------
// Peer learning forward table: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and quiet in reset.
// ---------------------------------------------------------------------------
`ifndef PEER_LEARNING_FORWARD_TABLE_DEFINES_SVH
`define PEER_LEARNING_FORWARD_TABLE_DEFINES_SVH

// Same-cycle implication
`define PLFT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("plft: same-cycle check failed");

// Next-cycle implication
`define PLFT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("plft: next-cycle check failed");

`endif

// ===== rtl/core/plft_pkg.sv =====
// ---------------------------------------------------------------------------
// Peer learning forward table package
// Sizes, word types, field codes and controller/datapath signal groups.
// ---------------------------------------------------------------------------
package plft_pkg;

  localparam int PEER_SLOTS  = 64;
  localparam int ROOM_BITS   = 64;
  localparam int MAX_RESULTS = 64;
  localparam int SLOT_W      = $clog2(PEER_SLOTS);
  localparam int SCAN_W      = $clog2(PEER_SLOTS + 1);
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int CFG_ADDR_W  = 3;

  localparam logic [30:0] TIMEOUT_RESET = 31'd30000;
  localparam logic [31:0] ADDR_ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [CFG_ADDR_W-3:0] REG_TIMEOUT = '0;

  // Packet kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_PING  = 2'd1;
  localparam logic [1:0] KIND_PONG  = 2'd2;
  localparam logic [1:0] KIND_OTHER = 2'd3;

  // Result actions
  localparam logic [1:0] ACT_DELIVER = 2'd0;
  localparam logic [1:0] ACT_PONG    = 2'd1;
  localparam logic [1:0] ACT_DROP    = 2'd2;
  localparam logic [1:0] ACT_IGNORED = 2'd3;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [63:0] room_tag;
    logic [31:0] src_laddr;
    logic [31:0] dst_laddr;
    logic        broadcast_flag;
    logic [1:0]  packet_kind;
    logic [31:0] sender_addr;
    logic [15:0] sender_port;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] dest_addr;
    logic [15:0] dest_port;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [ROOM_BITS-1:0] room;
    logic [31:0]          laddr;
    logic [31:0]          naddr;
    logic [15:0]          nport;
    logic [31:0]          seen_ms;
  } entry_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_run;
    logic learn_mode;
    logic learn_write;
    logic emit_single;
    logic emit_final;
  } cmd_t;

  typedef struct packed {
    logic scan_end;
    logic learn_hit;
    logic out_free;
    logic single;
  } sts_t;

endpackage

// ===== rtl/core/peer_learning_forward_table.sv =====
// ---------------------------------------------------------------------------
// Peer learning forward table
// Relay forwarding table: learns each sender with aging and oldest-entry
// eviction, then gives one delivery word per matching peer in the room.
//
//   Channel | Direction | Handshake          | Word
//   in      | input     | in_valid/in_ready  | plft_pkg::in_item_t
//   out     | output    | out_valid/out_ready| plft_pkg::out_item_t
//   cfg     | input     | APB psel/penable   | peer_timeout_ms at 0x0
//
// The learn scan and the forward scan each read the entry memory one slot per
// cycle through its single read port, unless a stall holds the forward scan.
// A learn hit ends the learn scan early. Reset clears the valid flags at once;
// no clearing pass. A stalled output holds the forward scan when a second
// delivery is found while the output word waits, and the closing word of each
// header waits for the output register.
// ---------------------------------------------------------------------------
module peer_learning_forward_table (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  plft_pkg::in_item_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output plft_pkg::out_item_t        out_data_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [plft_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import plft_pkg::*;

  logic [30:0] timeout_q;
  logic        reg_sel;
  cmd_t        cmd;
  sts_t        sts;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[CFG_ADDR_W-1:2] == REG_TIMEOUT);
  assign prdata  = reg_sel ? {1'b0, timeout_q} : '0;

  // Write the timeout register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      timeout_q <= pwdata[30:0];
    end
  end

  plft_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  plft_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .timeout_i   (timeout_q),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/core/plft_ctrl.sv =====
// ---------------------------------------------------------------------------
// Peer learning forward table controller
// Sequences load, learn scan, learn write, route decision, forward scan and
// the closing result of each header word.
// ---------------------------------------------------------------------------
module plft_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  plft_pkg::sts_t sts_i,
  output plft_pkg::cmd_t cmd_o
);
  import plft_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_LEARN, S_LWRITE, S_ROUTE, S_FWD, S_FINAL, S_SINGLE
  } state_e;

  state_e state_q, state_d;

  // Decode commands and next state
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load       = 1'b1;
          cmd_o.scan_start = 1'b1;
          state_d          = S_LEARN;
        end
      end
      S_LEARN: begin
        cmd_o.scan_run   = 1'b1;
        cmd_o.learn_mode = 1'b1;
        if (sts_i.learn_hit) begin
          state_d = S_ROUTE;
        end else if (sts_i.scan_end) begin
          state_d = S_LWRITE;
        end
      end
      S_LWRITE: begin
        cmd_o.learn_write = 1'b1;
        state_d           = S_ROUTE;
      end
      S_ROUTE: begin
        if (sts_i.single) begin
          state_d = S_SINGLE;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = S_FWD;
        end
      end
      S_FWD: begin
        cmd_o.scan_run = 1'b1;
        if (sts_i.scan_end) begin
          state_d = S_FINAL;
        end
      end
      S_FINAL: begin
        if (sts_i.out_free) begin
          cmd_o.emit_final = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_SINGLE: begin
        if (sts_i.out_free) begin
          cmd_o.emit_single = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/plft_datapath.sv =====
// ---------------------------------------------------------------------------
// Peer learning forward table datapath
// Entry memory with valid flags, a stallable one-slot-per-cycle scan pipeline
// for learning and forwarding, a pending delivery slot and output register.
// ---------------------------------------------------------------------------
`include "peer_learning_forward_table_defines.svh"

module plft_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  plft_pkg::in_item_t  in_data_i,
  input  logic [30:0]         timeout_i,
  input  plft_pkg::cmd_t      cmd_i,
  output plft_pkg::sts_t      sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output plft_pkg::out_item_t out_data_o
);
  import plft_pkg::*;

  in_item_t              in_q;
  entry_t                mem [PEER_SLOTS];
  entry_t                rdata_q;
  logic [PEER_SLOTS-1:0] valid_q;
  logic [SCAN_W-1:0]     scan_addr_q;
  logic                  ev_vld_q;
  logic [SLOT_W-1:0]     ev_idx_q;
  logic                  free_vld_q, old_vld_q;
  logic [SLOT_W-1:0]     free_idx_q, old_idx_q;
  logic [31:0]           old_age_q;
  logic                  pend_vld_q;
  logic [31:0]           pend_addr_q;
  logic [15:0]           pend_port_q;
  logic [CNT_W-1:0]      dcnt_q;
  logic                  out_vld_q;
  out_item_t             out_q;

  logic [31:0]     age;
  logic            ent_v, expired, live, room_eq, learn_hit, bcast, deliver;
  logic            stall, advance, out_free, mem_we, out_load, rd_more;
  logic [SLOT_W-1:0] wr_idx;
  entry_t          wr_data;
  out_item_t       out_d;

  // Evaluate the slot at the head of the scan
  always_comb begin
    age       = in_q.now_ms - rdata_q.seen_ms;
    ent_v     = valid_q[ev_idx_q];
    expired   = ent_v && (age > {1'b0, timeout_i});
    live      = ent_v && !expired;
    room_eq   = (rdata_q.room == in_q.room_tag[ROOM_BITS-1:0]);
    learn_hit = ev_vld_q && live && room_eq && (rdata_q.laddr == in_q.src_laddr);
    bcast     = in_q.broadcast_flag || (in_q.dst_laddr == ADDR_ALL_ONES);
    deliver   = !cmd_i.learn_mode && ev_vld_q && live && room_eq &&
                (bcast ? (rdata_q.laddr != in_q.src_laddr)
                       : (rdata_q.laddr == in_q.dst_laddr)) &&
                (dcnt_q < CNT_W'(MAX_RESULTS));
  end

  assign out_free = !out_vld_q || out_ready_i;
  assign stall    = deliver && pend_vld_q && !out_free;
  assign advance  = cmd_i.scan_run && !stall;
  assign rd_more  = (scan_addr_q < SCAN_W'(PEER_SLOTS));

  // Learn write: refresh on hit, else first free slot, else oldest
  assign wr_idx  = (cmd_i.learn_mode && learn_hit) ? ev_idx_q
                 : (free_vld_q ? free_idx_q : old_idx_q);
  assign mem_we  = (advance && cmd_i.learn_mode && learn_hit) ||
                   (cmd_i.learn_write && (free_vld_q || old_vld_q));
  assign wr_data = '{room:    in_q.room_tag[ROOM_BITS-1:0],
                     laddr:   in_q.src_laddr,
                     naddr:   in_q.sender_addr,
                     nport:   in_q.sender_port,
                     seen_ms: in_q.now_ms};

  // Select the next output word
  always_comb begin
    out_load = 1'b0;
    out_d    = '0;
    if (cmd_i.emit_single) begin
      out_load = 1'b1;
      out_d.last = 1'b1;
      if (in_q.packet_kind == KIND_OTHER) begin
        out_d.action = ACT_IGNORED;
      end else begin
        out_d.action    = ACT_PONG;
        out_d.dest_addr = in_q.sender_addr;
        out_d.dest_port = in_q.sender_port;
      end
    end else if (cmd_i.emit_final) begin
      out_load   = 1'b1;
      out_d.last = 1'b1;
      if (pend_vld_q) begin
        out_d.action    = ACT_DELIVER;
        out_d.dest_addr = pend_addr_q;
        out_d.dest_port = pend_port_q;
      end else begin
        out_d.action = ACT_DROP;
      end
    end else if (advance && deliver && pend_vld_q) begin
      out_load        = 1'b1;
      out_d.action    = ACT_DELIVER;
      out_d.dest_addr = pend_addr_q;
      out_d.dest_port = pend_port_q;
    end
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_idx] <= wr_data;
    end
    if (advance && rd_more) begin
      rdata_q <= mem[scan_addr_q[SLOT_W-1:0]];
    end
  end

  // Capture the header word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q <= in_data_i;
    end
  end

  // Scan pipeline, trackers, valid flags, pending slot and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      scan_addr_q <= '0;
      ev_vld_q    <= 1'b0;
      ev_idx_q    <= '0;
      free_vld_q  <= 1'b0;
      free_idx_q  <= '0;
      old_vld_q   <= 1'b0;
      old_idx_q   <= '0;
      old_age_q   <= '0;
      pend_vld_q  <= 1'b0;
      pend_addr_q <= '0;
      pend_port_q <= '0;
      dcnt_q      <= '0;
      out_vld_q   <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cmd_i.scan_start) begin
        scan_addr_q <= '0;
        ev_vld_q    <= 1'b0;
        free_vld_q  <= 1'b0;
        old_vld_q   <= 1'b0;
        pend_vld_q  <= 1'b0;
        dcnt_q      <= '0;
      end else if (advance) begin
        // drop expired entries
        if (ev_vld_q && expired) begin
          valid_q[ev_idx_q] <= 1'b0;
        end
        if (cmd_i.learn_mode && ev_vld_q) begin
          if (!live && !free_vld_q) begin
            free_vld_q <= 1'b1;
            free_idx_q <= ev_idx_q;
          end
          if (live && (!old_vld_q || age > old_age_q)) begin
            old_vld_q <= 1'b1;
            old_idx_q <= ev_idx_q;
            old_age_q <= age;
          end
        end
        if (deliver) begin
          pend_vld_q  <= 1'b1;
          pend_addr_q <= rdata_q.naddr;
          pend_port_q <= rdata_q.nport;
          dcnt_q      <= dcnt_q + 1'b1;
        end
        // advance the read stage
        ev_vld_q <= rd_more;
        if (rd_more) begin
          ev_idx_q    <= scan_addr_q[SLOT_W-1:0];
          scan_addr_q <= scan_addr_q + 1'b1;
        end
      end
      if (mem_we) begin
        valid_q[wr_idx] <= 1'b1;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
        out_q     <= out_d;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign sts_o.scan_end  = !ev_vld_q && !rd_more;
  assign sts_o.learn_hit = learn_hit;
  assign sts_o.out_free  = out_free;
  assign sts_o.single    = (in_q.packet_kind == KIND_OTHER) ||
                           ((in_q.packet_kind == KIND_PING) &&
                            ((in_q.dst_laddr == '0) || (in_q.dst_laddr == ADDR_ALL_ONES)));

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  `PLFT_ASSERT_NOW(a_out_load_free, out_load, out_free)
  `PLFT_ASSERT_NOW(a_dcnt_bound, 1'b1, dcnt_q <= CNT_W'(MAX_RESULTS))
  `PLFT_ASSERT_NEXT(a_write_sets_valid, mem_we, valid_q[$past(wr_idx)])
  `PLFT_ASSERT_NOW(a_scan_excl, cmd_i.scan_start, !cmd_i.scan_run && !out_load)

endmodule

// ===== dv/peer_learning_forward_table_tb.sv =====
// ----------------------------------------------------------------------------
// Peer learning forward table testbench
// Drives packet headers through the valid/ready input and checks every
// result word against an in-bench table model that learns, ages, evicts and
// routes. Covers directed corner cases, random traffic under several timeout
// settings, random idling on both sides and a long output stall.
// ----------------------------------------------------------------------------
module peer_learning_forward_table_tb;
  import plft_pkg::*;

  localparam int WATCHDOG_CYCLES = 6000;
  localparam int HOLD_CYCLES     = 1500;
  localparam int DRAIN_CYCLES    = 150;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic       in_valid  = 1'b0;
  logic       in_ready;
  in_item_t   in_data   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [31:0]           pwdata  = '0;
  logic [31:0]           prdata;
  logic                  pready;

  // Stimulus and expectation stores
  in_item_t  hdr_pend_q[$];
  out_item_t route_q[$];
  int        err_cnt   = 0;
  int        idle_mode = 2;
  int        hold_trig = 0;

  // Table model state
  logic [30:0] tmo_ms;
  bit          tbl_valid[PEER_SLOTS];
  logic [63:0] tbl_room[PEER_SLOTS];
  logic [31:0] tbl_laddr[PEER_SLOTS];
  logic [31:0] tbl_naddr[PEER_SLOTS];
  logic [15:0] tbl_nport[PEER_SLOTS];
  logic [31:0] tbl_seen[PEER_SLOTS];

  // Random pools
  logic [63:0] room_pool[8];
  logic [31:0] ip_pool[128];
  logic [31:0] clock_ms;

  always #6 clk_i = ~clk_i;

  peer_learning_forward_table i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Learn the sender: age, refresh on match, else fill a free slot or evict
  task automatic learn_sender(input in_item_t h);
    int          free_slot;
    int          old_slot;
    logic [31:0] old_age;
    logic [31:0] age;
    free_slot = -1;
    old_slot  = -1;
    old_age   = '0;
    for (int i = 0; i < PEER_SLOTS; i++) begin
      age = h.now_ms - tbl_seen[i];
      if (tbl_valid[i] && age > {1'b0, tmo_ms}) tbl_valid[i] = 1'b0;
      if (tbl_valid[i] && tbl_laddr[i] == h.src_laddr && tbl_room[i] == h.room_tag) begin
        tbl_naddr[i] = h.sender_addr;
        tbl_nport[i] = h.sender_port;
        tbl_seen[i]  = h.now_ms;
        return;
      end
      if (!tbl_valid[i] && free_slot < 0) free_slot = i;
      if (tbl_valid[i] && (old_slot < 0 || age > old_age)) begin
        old_slot = i;
        old_age  = age;
      end
    end
    if (free_slot < 0) free_slot = old_slot;
    if (free_slot < 0) return;
    tbl_valid[free_slot] = 1'b1;
    tbl_room[free_slot]  = h.room_tag;
    tbl_laddr[free_slot] = h.src_laddr;
    tbl_naddr[free_slot] = h.sender_addr;
    tbl_nport[free_slot] = h.sender_port;
    tbl_seen[free_slot]  = h.now_ms;
  endtask

  // Compute the result words of one accepted header
  task automatic predict_route(input in_item_t h);
    out_item_t res[$];
    out_item_t w;
    bit        bcast;
    logic [31:0] age;
    bcast = h.broadcast_flag || h.dst_laddr == ADDR_ALL_ONES;
    learn_sender(h);
    w = '0;
    if (h.packet_kind == KIND_OTHER) begin
      w.action = ACT_IGNORED;
      res.push_back(w);
    end else if (h.packet_kind == KIND_PING &&
                 (h.dst_laddr == '0 || h.dst_laddr == ADDR_ALL_ONES)) begin
      w.action    = ACT_PONG;
      w.dest_addr = h.sender_addr;
      w.dest_port = h.sender_port;
      res.push_back(w);
    end else begin
      for (int i = 0; i < PEER_SLOTS; i++) begin
        if (!tbl_valid[i]) continue;
        age = h.now_ms - tbl_seen[i];
        if (age > {1'b0, tmo_ms}) begin
          tbl_valid[i] = 1'b0;
          continue;
        end
        if (tbl_room[i] != h.room_tag) continue;
        if (bcast ? (tbl_laddr[i] == h.src_laddr) : (tbl_laddr[i] != h.dst_laddr)) continue;
        if (res.size() < MAX_RESULTS) begin
          w.action    = ACT_DELIVER;
          w.dest_addr = tbl_naddr[i];
          w.dest_port = tbl_nport[i];
          res.push_back(w);
        end
      end
      if (res.size() == 0) begin
        w.action = ACT_DROP;
        res.push_back(w);
      end
    end
    for (int k = 0; k < res.size(); k++) begin
      w      = res[k];
      w.last = (k == res.size() - 1);
      route_q.push_back(w);
    end
  endtask

  // Sender: offer the next pending word, hold it until accepted
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (hdr_pend_q.size() != 0 &&
          $urandom_range(99) >= (idle_mode == 0 ? 13 : idle_mode == 1 ? 63 : 0)) begin
        in_valid <= 1'b1;
        in_data  <= hdr_pend_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off on request
  int hold_left = 0;
  int hold_seen = 0;
  always @(posedge clk_i) begin
    if (hold_trig != hold_seen) begin
      hold_seen = hold_trig;
      hold_left = HOLD_CYCLES;
    end
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= $urandom_range(99) >= (idle_mode == 0 ? 63 : idle_mode == 1 ? 13 : 0);
    end
  end

  // Monitor: predict on input acceptance, check each output word
  always @(posedge clk_i) begin
    out_item_t exp_w;
    if (rst_ni && in_valid && in_ready) predict_route(in_data);
    if (rst_ni && out_valid && out_ready) begin
      if (route_q.size() == 0) begin
        $display("%0t: unexpected word %h", $time, out_data);
        err_cnt++;
      end else begin
        exp_w = route_q.pop_front();
        if (exp_w.action !== out_data.action || exp_w.dest_addr !== out_data.dest_addr ||
            exp_w.dest_port !== out_data.dest_port || exp_w.last !== out_data.last) begin
          $display("%0t: mismatch expected act=%0d addr=%h port=%h last=%0d",
                   $time, exp_w.action, exp_w.dest_addr, exp_w.dest_port, exp_w.last);
          $display("%0t:          actual   act=%0d addr=%h port=%h last=%0d",
                   $time, out_data.action, out_data.dest_addr, out_data.dest_port,
                   out_data.last);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog on cycles with no accepted word
  int quiet_cnt = 0;
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      quiet_cnt <= 0;
    end else if (quiet_cnt == WATCHDOG_CYCLES) begin
      $display("peer_learning_forward_table test failed");
      $finish;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
  end

  // Read the timeout register and compare with the model
  task automatic timeout_read_check();
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= {REG_TIMEOUT, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[30:0] !== tmo_ms) begin
      $display("%0t: timeout readback expected %h actual %h", $time, tmo_ms, prdata);
      err_cnt++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic timeout_write(input logic [30:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {REG_TIMEOUT, 2'b00};
    pwdata  <= {1'b0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    tmo_ms = val;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    timeout_read_check();
  endtask

  function automatic in_item_t mk_hdr(logic [31:0] now, logic [63:0] room, logic [31:0] src,
                                      logic [31:0] tgt, logic flag, logic [1:0] kind,
                                      logic [31:0] naddr, logic [15:0] nport);
    in_item_t h;
    h = '{now, room, src, tgt, flag, kind, naddr, nport};
    return h;
  endfunction

  // Queue random headers drawn from small room and address pools
  task automatic queue_random(input int count, input int n_ip, input int n_room,
                              input int max_step);
    in_item_t h;
    int       pick;
    for (int n = 0; n < count; n++) begin
      clock_ms += $urandom_range(max_step);
      h.now_ms   = clock_ms;
      h.room_tag = ($urandom_range(49) == 0) ? {$urandom, $urandom}
                                              : room_pool[$urandom_range(n_room - 1)];
      h.src_laddr = ip_pool[$urandom_range(n_ip - 1)];
      pick = $urandom_range(99);
      h.dst_laddr = pick < 55 ? ip_pool[$urandom_range(n_ip - 1)] :
                    pick < 65 ? ADDR_ALL_ONES : pick < 75 ? 32'h0 : $urandom;
      h.broadcast_flag = ($urandom_range(4) == 0);
      h.packet_kind    = 2'($urandom_range(3));
      h.sender_addr    = $urandom;
      h.sender_port    = 16'($urandom);
      hdr_pend_q.push_back(h);
    end
  endtask

  task automatic wait_idle();
    while (hdr_pend_q.size() != 0 || in_valid || route_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    logic [63:0] rh;
    tmo_ms = TIMEOUT_RESET;
    foreach (tbl_valid[i]) begin
      tbl_valid[i] = 1'b0;
      tbl_seen[i]  = '0;
    end
    foreach (room_pool[i]) room_pool[i] = {$urandom, $urandom};
    foreach (ip_pool[i]) ip_pool[i] = $urandom;
    rh = 64'hFFFF_FFFF_FFFF_FFFF;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    timeout_read_check();

    // Directed: routing kinds, relay pings, self delivery, aging and wrap
    idle_mode = 0;
    hdr_pend_q.push_back(mk_hdr(1000, rh, 1, 2, 0, KIND_DATA, 32'hA, 16'h1));
    hdr_pend_q.push_back(mk_hdr(1001, rh, 2, 1, 0, KIND_DATA, 32'hB, 16'h2));
    hdr_pend_q.push_back(mk_hdr(1002, rh, 3, 0, 0, KIND_PING, 32'hC, 16'h3));
    hdr_pend_q.push_back(mk_hdr(1003, rh, 3, ADDR_ALL_ONES, 0, KIND_PING, 32'hC, 16'h3));
    hdr_pend_q.push_back(mk_hdr(1004, rh, 1, 3, 0, KIND_PING, 32'hA, 16'h1));
    hdr_pend_q.push_back(mk_hdr(1005, rh, 2, 1, 1, KIND_PONG, 32'hB, 16'h2));
    hdr_pend_q.push_back(mk_hdr(1006, rh, 1, ADDR_ALL_ONES, 0, KIND_DATA, 32'hA, 16'h1));
    hdr_pend_q.push_back(mk_hdr(1007, rh, 2, 1, 1, KIND_OTHER, 32'hB, 16'h2));
    hdr_pend_q.push_back(mk_hdr(1008, rh, 1, 1, 0, KIND_DATA, 32'hA, 16'h1));
    hdr_pend_q.push_back(mk_hdr(1009, '0, ADDR_ALL_ONES, 0, 0, KIND_DATA,
                                ADDR_ALL_ONES, 16'hFFFF));
    hdr_pend_q.push_back(mk_hdr(1010, '0, 0, ADDR_ALL_ONES, 0, KIND_DATA, 0, 0));
    hdr_pend_q.push_back(mk_hdr(1010, rh, 4, 2, 1, KIND_PING, 32'hD, 16'h4));
    // exactly at the timeout stays live, one past expires
    hdr_pend_q.push_back(mk_hdr(31008, rh, 5, 1, 0, KIND_DATA, 32'hE, 16'h5));
    hdr_pend_q.push_back(mk_hdr(31010, rh, 5, ADDR_ALL_ONES, 0, KIND_PONG, 32'hE, 16'h5));
    // time wraps across zero
    hdr_pend_q.push_back(mk_hdr(32'hFFFF_FFF0, rh, 1, 2, 0, KIND_DATA, 32'hA, 16'h1));
    hdr_pend_q.push_back(mk_hdr(32'h0000_0010, rh, 2, 1, 1, KIND_DATA, 32'hB, 16'h2));
    hdr_pend_q.push_back(mk_hdr(32'h0000_0020, rh, 6, 7, 0, KIND_OTHER, 32'hF, 16'h6));
    wait_idle();

    // Smallest timeout: almost everything expires
    timeout_write(31'd1);
    idle_mode = 0;
    clock_ms  = $urandom;
    queue_random(80, 6, 2, 2);
    wait_idle();

    // Largest timeout, many sources: table fills and evicts, long output stall
    timeout_write(31'h7FFF_FFFF);
    idle_mode = 1;
    queue_random(160, 90, 1, 50);
    hold_trig++;
    wait_idle();

    // Mid timeout with time near wrap
    timeout_write(31'd400);
    idle_mode = 2;
    clock_ms  = 32'hFFFF_8000;
    queue_random(120, 10, 3, 300);
    wait_idle();

    timeout_write(TIMEOUT_RESET);
    idle_mode = 2;
    queue_random(100, 20, 4, 3000);
    wait_idle();

    if (err_cnt == 0) begin
      $display("peer_learning_forward_table test passed");
    end else begin
      $display("peer_learning_forward_table test failed");
    end
    $finish;
  end

endmodule
